### hw/rtl/swrb_pkg.sv
// Shared types and constants for the sliding window retransmit buffer.
// No dependencies; compiled first, ahead of every file that uses it.
`timescale 1ns / 1ps
`default_nettype none

package swrb_pkg;

    // Fixed field widths
    localparam int CFG_W    = 5;
    localparam int ACTION_W = 3;
    localparam int SEQ_W    = 32;
    localparam int OFF_W    = 11;
    localparam int BYTE_W   = 8;

    // Reset values
    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd8;
    localparam logic [SEQ_W-1:0] EDGE_RESET   = 32'd1;

    // Action codes; six and seven do nothing
    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE     = 3'd0,
        ACT_FREE      = 3'd1,
        ACT_READ      = 3'd2,
        ACT_READ_LOW  = 3'd3,
        ACT_SLIDE     = 3'd4,
        ACT_ADVANCE   = 3'd5
    } t_action;

endpackage

`default_nettype wire

### hw/rtl/swrb_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on swrb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swrb_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [swrb_pkg::ACTION_W-1:0]      action;
    logic [swrb_pkg::SEQ_W-1:0]         seq_number;
    logic [swrb_pkg::OFF_W-1:0]         byte_offset;
    logic [swrb_pkg::BYTE_W-1:0]        byte_value;
    logic                               last_byte;

    modport source (output valid, action, seq_number, byte_offset, byte_value, last_byte,
                    input ready);
    modport sink   (input valid, action, seq_number, byte_offset, byte_value, last_byte,
                    output ready);
endinterface

interface swrb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               slot_valid;
    logic [swrb_pkg::BYTE_W-1:0]        read_byte;
    logic                               window_is_full;
    logic [swrb_pkg::SEQ_W-1:0]         lower_out;
    logic [swrb_pkg::SEQ_W-1:0]         next_out;

    modport source (output valid, slot_valid, read_byte, window_is_full, lower_out, next_out,
                    input ready);
    modport sink   (input valid, slot_valid, read_byte, window_is_full, lower_out, next_out,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/swrb_ram.sv
// Generic single-port RAM with registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/sliding_window_retransmit_buffer.sv
// Top level of the sliding window retransmit buffer.
// Depends on swrb_pkg, swrb_cmd_if / swrb_rsp_if and swrb_ram.
`timescale 1ns / 1ps
`default_nettype none

// Sender-side selective-repeat store. Each command transfer carries an action
// (write byte, free slot, read byte, read byte at the lower edge, slide lower
// edge, advance next-to-send) and yields exactly one result transfer with the
// slot's valid flag, the byte read, the window-full flag and both edges after
// the action. Packet bytes live in one RAM of MAX_SLOTS * PACKET_BYTES bytes;
// slot flags are flip-flops cleared at reset, so no clearing pass is needed and
// the block accepts commands right after reset. A command is accepted, then
// the remainder unit reduces the 32-bit sequence number and the lower edge
// modulo the window size four bits per cycle, then the RAM is accessed and
// state is updated and the result register loaded. PACKET_BYTES must be a
// power of two; the byte offset wraps by masking. A finished result waits in
// the output register while the next command is taken. The user writes the
// window size register only while idle; the block does not enforce this.
module sliding_window_retransmit_buffer #(
    parameter int MAX_SLOTS    = 16,
    parameter int PACKET_BYTES = 2048
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [swrb_pkg::CFG_W-1:0]  i_cfg_wdata,
    swrb_cmd_if.sink                         i_in,
    swrb_rsp_if.source                       o_out
);

    localparam int CFG_W     = swrb_pkg::CFG_W;
    localparam int SEQ_W     = swrb_pkg::SEQ_W;
    localparam int OFF_W     = swrb_pkg::OFF_W;
    localparam int BYTE_W    = swrb_pkg::BYTE_W;
    localparam int STEP      = 4;                       // bits reduced per cycle
    localparam int ITERS     = SEQ_W / STEP;
    localparam int ITER_W    = $clog2(ITERS);
    localparam int PB_W      = $clog2(PACKET_BYTES);
    localparam int OFF_EXT_W = (OFF_W > PB_W) ? OFF_W : PB_W;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ADDR_W    = $clog2(MAX_SLOTS * PACKET_BYTES);
    localparam int SIZE_TOP  = (1 << CFG_W) - 1;
    localparam int CLAMP     = (MAX_SLOTS < SIZE_TOP) ? MAX_SLOTS : SIZE_TOP;
    localparam logic [CFG_W-1:0]  SIZE_MAX  = CLAMP[CFG_W-1:0];
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MEM,
        S_FIN
    } t_state;

    // Control and architectural state
    t_state                     r_state;
    logic [ITER_W-1:0]          r_iter;
    logic [CFG_W-1:0]           r_window_size;
    logic [SEQ_W-1:0]           r_lower;
    logic [SEQ_W-1:0]           r_next;
    logic                       r_flags [MAX_SLOTS];
    logic                       r_out_valid;

    // Captured command and remainder datapath
    logic [swrb_pkg::ACTION_W-1:0] r_action;
    logic [BYTE_W-1:0]          r_byte;
    logic                       r_last;
    logic [CFG_W-1:0]           r_eff;
    logic [SEQ_W-1:0]           r_seq_sh;   // rotates back to the sequence number
    logic [SEQ_W-1:0]           r_low_sh;
    logic [CFG_W-1:0]           r_rem_seq;
    logic [CFG_W-1:0]           r_rem_low;
    logic [PB_W-1:0]            r_rem_off;

    // Result payload registers
    logic                       r_out_slot_valid;
    logic [BYTE_W-1:0]          r_out_read_byte;
    logic                       r_out_full;
    logic [SEQ_W-1:0]           r_out_lower;
    logic [SEQ_W-1:0]           r_out_next;

    logic [CFG_W-1:0]           n_eff;
    logic [CFG_W-1:0]           n_rem_seq;
    logic [CFG_W-1:0]           n_rem_low;
    logic [OFF_EXT_W-1:0]       off_ext;
    logic [SLOT_W-1:0]          slot_seq;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_we;
    logic                       mem_re;
    logic [BYTE_W-1:0]          mem_rdata;
    logic                       n_flag;
    logic                       n_flag_valid;
    logic [SEQ_W-1:0]           n_lower;
    logic [SEQ_W-1:0]           n_next;
    logic [BYTE_W-1:0]          n_read_byte;
    logic                       in_xfer;
    logic                       out_free;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Offset wraps at the packet size by keeping the low bits
    assign off_ext = OFF_EXT_W'(i_in.byte_offset);

    // Effective window size: zero acts as one, large values clamp
    always_comb begin
        if (r_window_size == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_window_size > SIZE_MAX) begin
            n_eff = SIZE_MAX;
        end else begin
            n_eff = r_window_size;
        end
    end

    // Restoring remainder step, four bits per cycle for each chain
    always_comb begin
        logic [CFG_W:0] acc_s;
        logic [CFG_W:0] acc_l;
        n_rem_seq = r_rem_seq;
        n_rem_low = r_rem_low;
        for (int k = 0; k < STEP; k++) begin
            acc_s = {n_rem_seq, r_seq_sh[SEQ_W-1-k]};
            if (acc_s >= {1'b0, r_eff}) begin
                acc_s = acc_s - {1'b0, r_eff};
            end
            n_rem_seq = acc_s[CFG_W-1:0];

            acc_l = {n_rem_low, r_low_sh[SEQ_W-1-k]};
            if (acc_l >= {1'b0, r_eff}) begin
                acc_l = acc_l - {1'b0, r_eff};
            end
            n_rem_low = acc_l[CFG_W-1:0];
        end
    end

    // Slot index from the remainder, resized to the flag array
    always_comb begin
        logic [SLOT_W+CFG_W-1:0] ext_s;
        ext_s    = {{SLOT_W{1'b0}}, r_rem_seq};
        slot_seq = ext_s[SLOT_W-1:0];
    end

    // Byte RAM address: slot base plus reduced offset
    always_comb begin
        logic [ADDR_W+CFG_W-1:0] slot_ext;
        if (r_action == swrb_pkg::ACT_READ_LOW) begin
            slot_ext = {{ADDR_W{1'b0}}, r_rem_low};
        end else begin
            slot_ext = {{ADDR_W{1'b0}}, r_rem_seq};
        end
        mem_addr = ADDR_W'(slot_ext[ADDR_W-1:0] * ADDR_W'(PACKET_BYTES))
                 + ADDR_W'(r_rem_off);
    end

    assign mem_we = (r_state == S_MEM) && (r_action == swrb_pkg::ACT_WRITE);
    assign mem_re = (r_state == S_MEM);

    swrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_SLOTS * PACKET_BYTES)
    ) u_bytes (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_byte),
        .o_rdata (mem_rdata)
    );

    // State after the action, used for the update and the result
    always_comb begin
        n_flag       = r_flags[slot_seq];
        n_flag_valid = 1'b0;
        n_lower      = r_lower;
        n_next       = r_next;
        n_read_byte  = '0;
        case (r_action)
            swrb_pkg::ACT_WRITE: begin
                if (r_last) begin
                    n_flag       = 1'b1;
                    n_flag_valid = 1'b1;
                end
            end
            swrb_pkg::ACT_FREE: begin
                n_flag       = 1'b0;
                n_flag_valid = 1'b1;
            end
            swrb_pkg::ACT_READ,
            swrb_pkg::ACT_READ_LOW: begin
                n_read_byte = mem_rdata;
            end
            swrb_pkg::ACT_SLIDE: begin
                n_lower = r_seq_sh;
            end
            swrb_pkg::ACT_ADVANCE: begin
                n_next = r_next + SEQ_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Sequencer, architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_iter        <= '0;
            r_window_size <= swrb_pkg::WINDOW_RESET;
            r_lower       <= swrb_pkg::EDGE_RESET;
            r_next        <= swrb_pkg::EDGE_RESET;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_flags[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
            end
            // in S_FIN the result load below decides the flag
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_action  <= i_in.action;
                        r_byte    <= i_in.byte_value;
                        r_last    <= i_in.last_byte;
                        r_eff     <= n_eff;
                        r_seq_sh  <= i_in.seq_number;
                        r_low_sh  <= r_lower;
                        r_rem_seq <= '0;
                        r_rem_low <= '0;
                        r_rem_off <= off_ext[PB_W-1:0];
                        r_iter    <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem_seq <= n_rem_seq;
                    r_rem_low <= n_rem_low;
                    r_seq_sh  <= {r_seq_sh[SEQ_W-STEP-1:0], r_seq_sh[SEQ_W-1 -: STEP]};
                    r_low_sh  <= {r_low_sh[SEQ_W-STEP-1:0], {STEP{1'b0}}};
                    r_iter    <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_LAST) begin
                        r_state <= S_MEM;
                    end
                end
                S_MEM: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        if (n_flag_valid) begin
                            r_flags[slot_seq] <= n_flag;
                        end
                        r_lower          <= n_lower;
                        r_next           <= n_next;
                        r_out_valid      <= 1'b1;
                        r_out_slot_valid <= n_flag;
                        r_out_read_byte  <= n_read_byte;
                        r_out_full       <= (n_next == n_lower + SEQ_W'(r_eff));
                        r_out_lower      <= n_lower;
                        r_out_next       <= n_next;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.slot_valid     = r_out_slot_valid;
    assign o_out.read_byte      = r_out_read_byte;
    assign o_out.window_is_full = r_out_full;
    assign o_out.lower_out      = r_out_lower;
    assign o_out.next_out       = r_out_next;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for sliding_window_retransmit_buffer.
// Depends on swrb_pkg, swrb_cmd_if / swrb_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int          ACTION_W     = swrb_pkg::ACTION_W;
    localparam int          SEQ_W        = swrb_pkg::SEQ_W;
    localparam int          OFF_W        = swrb_pkg::OFF_W;
    localparam int          BYTE_W       = swrb_pkg::BYTE_W;
    localparam int          CFG_W        = swrb_pkg::CFG_W;
    localparam int          MAX_SLOTS    = 16;
    localparam int          PACKET_BYTES = 2048;
    localparam int          PHASE_ITEMS  = 215;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          MAX_PRINTS   = 40;
    // codes the block leaves without effect
    localparam logic [ACTION_W-1:0] ACT_NOP6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_NOP7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    seq;
        logic [OFF_W-1:0]    off;
        logic [BYTE_W-1:0]   val;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic              slot_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              full;
        logic [SEQ_W-1:0]  lower;
        logic [SEQ_W-1:0]  next;
    } t_status;

    typedef struct packed {
        t_cmd    cmd;
        logic    typed;
        t_status want;
    } t_row;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;

    swrb_cmd_if cmd_ch();
    swrb_rsp_if rsp_ch();

    sliding_window_retransmit_buffer #(
        .MAX_SLOTS    (MAX_SLOTS),
        .PACKET_BYTES (PACKET_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cmd_ch),
        .o_out       (rsp_ch)
    );

    always #6 clk = ~clk;

    // Window model: edges, slot flags, packet bytes and the size register
    logic [CFG_W-1:0]   win_cfg;
    logic [SEQ_W-1:0]   lower_q;
    logic [SEQ_W-1:0]   next_q;
    bit                 slot_flag[MAX_SLOTS];
    logic [BYTE_W-1:0]  byte_store[int unsigned];
    int unsigned        written_offs[MAX_SLOTS][$];

    t_status            pending_status[$];
    t_row               directed_rows[$];

    int unsigned        src_idle_pct;
    int unsigned        sink_stall_pct;
    int unsigned        cycle_count = 0;
    int unsigned        mismatches = 0;
    int unsigned        results_checked = 0;
    int unsigned        full_seen = 0;
    int unsigned        settings_run;
    int unsigned        action_seen[8];

    function automatic int unsigned eff_window();
        if (win_cfg == 0) return 1;
        if (win_cfg > MAX_SLOTS) return MAX_SLOTS;
        return 32'(win_cfg);
    endfunction

    // Apply one command to the model and return the status it yields
    function automatic t_status window_step(input t_cmd c);
        int unsigned slot;
        int unsigned addr;
        t_status     s;
        slot = c.seq % eff_window();
        addr = slot * PACKET_BYTES + c.off;
        s = '0;
        case (c.action)
            swrb_pkg::ACT_WRITE: begin
                if (!byte_store.exists(addr)) written_offs[slot].push_back(32'(c.off));
                byte_store[addr] = c.val;
                if (c.last) slot_flag[slot] = 1'b1;
            end
            swrb_pkg::ACT_FREE: slot_flag[slot] = 1'b0;
            swrb_pkg::ACT_READ: begin
                if (byte_store.exists(addr)) s.read_byte = byte_store[addr];
            end
            swrb_pkg::ACT_READ_LOW: begin
                addr = (lower_q % eff_window()) * PACKET_BYTES + c.off;
                if (byte_store.exists(addr)) s.read_byte = byte_store[addr];
            end
            swrb_pkg::ACT_SLIDE:   lower_q = c.seq;
            swrb_pkg::ACT_ADVANCE: next_q = next_q + 1;
            default: ;
        endcase
        s.slot_valid = slot_flag[slot];
        s.full       = (next_q == lower_q + SEQ_W'(eff_window()));
        s.lower      = lower_q;
        s.next       = next_q;
        return s;
    endfunction

    // Random command, mostly well-formed traffic around the current window
    function automatic t_cmd pick_command();
        t_cmd        c;
        int unsigned w;
        int unsigned slot;
        int unsigned roll;
        int unsigned s;
        w = eff_window();
        c.action = swrb_pkg::ACT_WRITE;
        c.seq    = $urandom();
        c.off    = OFF_W'($urandom());
        c.val    = BYTE_W'($urandom());
        c.last   = 1'($urandom_range(0, 1));
        roll     = $urandom_range(0, 99);
        if (roll < 62 && roll >= 42) begin
            // read back a byte that is known to be stored in the window
            slot = $urandom_range(0, w - 1);
            for (s = 0; s < w; s++)
                if (written_offs[slot].size() == 0) slot = s;
            if (written_offs[slot].size() != 0) begin
                c.action = swrb_pkg::ACT_READ;
                c.seq    = ($urandom_range(0, 32'hFFFF_FFEF) / w) * w + slot;
                c.off    = OFF_W'(written_offs[slot][$urandom_range(0,
                                  written_offs[slot].size() - 1)]);
            end
        end else if (roll >= 62 && roll < 72) begin
            slot = lower_q % w;
            if (written_offs[slot].size() != 0) begin
                c.action = swrb_pkg::ACT_READ_LOW;
                c.off    = OFF_W'(written_offs[slot][$urandom_range(0,
                                  written_offs[slot].size() - 1)]);
            end else begin
                // fill the lower-edge packet first
                c.seq = lower_q;
            end
        end else if (roll >= 34 && roll < 42) begin
            c.action = swrb_pkg::ACT_FREE;
            if ($urandom_range(0, 3) != 0) c.seq = lower_q + $urandom_range(0, w - 1);
        end else if (roll >= 72 && roll < 80) begin
            c.action = swrb_pkg::ACT_SLIDE;
            if ($urandom_range(0, 4) != 0) c.seq = next_q - $urandom_range(0, w + 1);
        end else if (roll >= 80 && roll < 95) begin
            c.action = swrb_pkg::ACT_ADVANCE;
        end else if (roll >= 95) begin
            c.action = $urandom_range(0, 1) ? ACT_NOP6 : ACT_NOP7;
        end else begin
            if ($urandom_range(0, 4) != 0) c.seq = next_q + $urandom_range(0, w);
            if ($urandom_range(0, 7) != 0) c.off = OFF_W'($urandom_range(0, 23));
            c.last = ($urandom_range(0, 5) == 0);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH result %0d %s: got %h want %h",
                     results_checked, what, got, want);
    endtask

    // Present one command, wait for its transfer, record the expected status
    task automatic send_command(input t_cmd c, input logic typed, input t_status want);
        t_status predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= c.action;
        cmd_ch.seq_number  <= c.seq;
        cmd_ch.byte_offset <= c.off;
        cmd_ch.byte_value  <= c.val;
        cmd_ch.last_byte   <= c.last;
        do @(posedge clk); while (!cmd_ch.ready);
        predicted = window_step(c);
        pending_status.push_back(typed ? want : predicted);
        action_seen[c.action]++;
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_cfg    = v;
    endtask

    task automatic add_row(input logic [ACTION_W-1:0] a, input logic [SEQ_W-1:0] seq,
                           input logic [OFF_W-1:0] off, input logic [BYTE_W-1:0] val,
                           input logic last, input int typed, input int sv,
                           input logic [BYTE_W-1:0] rd, input int full,
                           input logic [SEQ_W-1:0] lo, input logic [SEQ_W-1:0] nx);
        t_row r;
        r.cmd   = '{action: a, seq: seq, off: off, val: val, last: last};
        r.typed = typed[0];
        r.want  = '{slot_valid: sv[0], read_byte: rd, full: full[0], lower: lo, next: nx};
        directed_rows.push_back(r);
    endtask

    // Result side: random stalls and in-order comparison
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("transfer with nothing pending", rsp_ch.lower_out, '0);
            end else begin
                t_status want;
                want = pending_status.pop_front();
                if (rsp_ch.slot_valid !== want.slot_valid)
                    report_mismatch("slot_valid", 32'(rsp_ch.slot_valid),
                                    32'(want.slot_valid));
                if (rsp_ch.read_byte !== want.read_byte)
                    report_mismatch("read_byte", 32'(rsp_ch.read_byte), 32'(want.read_byte));
                if (rsp_ch.window_is_full !== want.full)
                    report_mismatch("window_is_full", 32'(rsp_ch.window_is_full),
                                    32'(want.full));
                if (rsp_ch.lower_out !== want.lower)
                    report_mismatch("lower_out", rsp_ch.lower_out, want.lower);
                if (rsp_ch.next_out !== want.next)
                    report_mismatch("next_out", rsp_ch.next_out, want.next);
                if (want.full) full_seen++;
            end
            results_checked++;
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_retransmit_buffer regression: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] sizes[9];
        t_status          none;
        t_cmd             c;
        int unsigned      n;

        sizes = '{5'd8, 5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12, 5'd3, 5'd20};
        none  = '0;
        settings_run    = 1;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        foreach (action_seen[i]) action_seen[i] = 0;
        win_cfg = swrb_pkg::WINDOW_RESET;
        lower_q = swrb_pkg::EDGE_RESET;
        next_q  = swrb_pkg::EDGE_RESET;
        foreach (slot_flag[i]) slot_flag[i] = 1'b0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= '0;
        cmd_ch.seq_number  <= '0;
        cmd_ch.byte_offset <= '0;
        cmd_ch.byte_value  <= '0;
        cmd_ch.last_byte   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, field extremes, every action, wraps
        add_row(swrb_pkg::ACT_ADVANCE,  32'h0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_WRITE,    32'hFFFF_FFFF, 11'd2047, 8'hFF, 1'b1, 1, 1, 8'h00, 0,
                32'h1, 32'd2);
        add_row(swrb_pkg::ACT_READ,     32'd7, 11'd2047, 8'h00, 1'b0, 1, 1, 8'hFF, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_WRITE,    32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_WRITE,    32'd8, 11'd0, 8'hA5, 1'b0, 1, 0, 8'h00, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_READ,     32'h8000_0000, 11'd0, 8'h00, 1'b0, 1, 0, 8'hA5, 0,
                32'h1, 32'd2);
        add_row(swrb_pkg::ACT_WRITE,    32'd1, 11'd5, 8'h5A, 1'b1, 1, 1, 8'h00, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_READ_LOW, 32'd0, 11'd5, 8'h00, 1'b0, 1, 0, 8'h5A, 0, 32'h1,
                32'd2);
        add_row(swrb_pkg::ACT_FREE,     32'd15, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0, 32'h1,
                32'd2);
        // freeing a slot keeps its bytes
        add_row(swrb_pkg::ACT_READ,     32'd7, 11'd2047, 8'h00, 1'b0, 1, 0, 8'hFF, 0, 32'h1,
                32'd2);
        add_row(ACT_NOP6,     32'd1,         11'd0,    8'hFF, 1'b1, 1, 1, 8'h00, 0, 32'h1, 32'd2);
        add_row(ACT_NOP7,     32'hFFFF_FFFF, 11'd0,    8'hFF, 1'b1, 1, 0, 8'h00, 0, 32'h1, 32'd2);
        // upper edge wraps past zero
        add_row(swrb_pkg::ACT_SLIDE,    32'hFFFF_FFFF, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd2);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd3);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd4);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd5);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd6);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 1,
                32'hFFFF_FFFF, 32'd7);
        add_row(swrb_pkg::ACT_READ_LOW, 32'd1, 11'd2047, 8'h00, 1'b0, 1, 1, 8'hFF, 1,
                32'hFFFF_FFFF, 32'd7);
        add_row(swrb_pkg::ACT_ADVANCE,  32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'hFFFF_FFFF, 32'd8);
        add_row(swrb_pkg::ACT_SLIDE,    32'd0, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 1, 32'h0,
                32'd8);
        add_row(swrb_pkg::ACT_SLIDE,    32'h8000_0000, 11'd0, 8'h00, 1'b0, 1, 0, 8'h00, 0,
                32'h8000_0000, 32'd8);
        add_row(swrb_pkg::ACT_WRITE,    32'd3, 11'd1024, 8'h3C, 1'b1, 0, 0, 8'h00, 0, 32'h0,
                32'h0);
        add_row(swrb_pkg::ACT_FREE,     32'd1, 11'd0, 8'h00, 1'b0, 0, 0, 8'h00, 0, 32'h0,
                32'h0);
        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        // Random phases; each new window size is written once the block is idle
        foreach (sizes[p]) begin
            if (p != 0) begin
                write_window(sizes[p]);
                settings_run++;
            end
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                c = pick_command();
                send_command(c, 1'b0, none);
                n++;
            end
        end

        wait_drained();
        $display("covered %0d writes, %0d frees, %0d reads, %0d lower-edge reads, %0d slides,",
                 action_seen[swrb_pkg::ACT_WRITE], action_seen[swrb_pkg::ACT_FREE],
                 action_seen[swrb_pkg::ACT_READ], action_seen[swrb_pkg::ACT_READ_LOW],
                 action_seen[swrb_pkg::ACT_SLIDE]);
        $display("%0d advances over %0d window sizes; %0d results checked, full %0d times",
                 action_seen[swrb_pkg::ACT_ADVANCE], settings_run, results_checked, full_seen);
        if (mismatches == 0) begin
            $display("sliding_window_retransmit_buffer regression: pass");
        end else begin
            $display("sliding_window_retransmit_buffer regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/swrb_pkg.sv
hw/rtl/swrb_if.sv
hw/rtl/swrb_ram.sv
hw/rtl/sliding_window_retransmit_buffer.sv
dv/testbench.sv
